// ===== design/upqv_pkg.sv =====
package upqv_pkg;

    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h5A;
    localparam logic [7:0] CH_LOWER_LO = 8'h61;
    localparam logic [7:0] CH_LOWER_HI = 8'h7A;
    localparam logic [7:0] CH_HEX_UC_HI = 8'h46;
    localparam logic [7:0] CH_HEX_LC_HI = 8'h66;

    localparam logic [1:0] HEX_DIGITS = 2'd2;

    typedef struct packed {
        logic       seen_first;
        logic       failed;
        logic       in_query;
        logic       segment_nonempty;
        logic       query_started_empty;
        logic       in_value;
        logic       part_nonempty;
        logic [1:0] hex_pending;
    } parse_state_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)
              || (c >= CH_LOWER_LO && c <= CH_HEX_LC_HI)
              || (c >= CH_UPPER_LO && c <= CH_HEX_UC_HI);
    endfunction

    function automatic logic in_segment_class(input logic [7:0] c);
        in_segment_class = (c >= CH_LOWER_LO && c <= CH_LOWER_HI)
                        || (c >= CH_UPPER_LO && c <= CH_UPPER_HI)
                        || (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI)
                        || (c >= CH_DOLLAR && c <= CH_DOT)
                        || c == CH_BANG || c == CH_COLON || c == CH_SEMI
                        || c == CH_EQUAL || c == CH_UNDER || c == CH_TILDE
                        || c == CH_AT || c == CH_PERCENT;
    endfunction

endpackage

// ===== design/url_path_query_validator_unit.sv =====
// Checks an HTTP origin-form request target ("/path?query") that arrives one
// byte per transaction, with last_char set on the final byte. Only the final
// byte produces an output transaction, whose accepted bit is 1 for a valid
// target; all other bytes produce none. The block takes one byte per cycle
// back to back unless stalled: a byte is captured in an input register, the
// parse flags are updated by a single level of compare logic, and the verdict
// is held in an output register. A final byte goes through the input register
// and then the output register. The input stalls only when an earlier verdict
// is still waiting downstream and the byte in the input register is a final byte.
module url_path_query_validator_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] character,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted
);

    logic                   s1_valid_reg;
    logic [7:0]             s1_char_reg;
    logic                   s1_last_reg;
    upqv_pkg::parse_state_t state_reg;
    upqv_pkg::parse_state_t state_next;
    logic                   out_valid_reg;
    logic                   accepted_reg;
    logic                   ok;
    logic                   out_free;
    logic                   advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;

    always_comb
    begin
        upqv_pkg::parse_state_t st;
        logic [7:0]             c;
        st = state_reg;
        c  = s1_char_reg;
        if (!state_reg.failed)
        begin
            if (!state_reg.seen_first)
            begin
                st.seen_first = 1'b1;
                if (c != upqv_pkg::CH_SLASH)
                    st.failed = 1'b1;
            end
            else if (state_reg.hex_pending != 2'd0)
            begin
                if (!upqv_pkg::is_hex(c))
                    st.failed = 1'b1;
                else
                begin
                    st.hex_pending = state_reg.hex_pending - 2'd1;
                    if (state_reg.in_query)
                        st.part_nonempty = 1'b1;
                    else
                        st.segment_nonempty = 1'b1;
                end
            end
            else if (!state_reg.in_query)
            begin
                if (c == upqv_pkg::CH_SLASH)
                begin
                    if (!state_reg.segment_nonempty)
                        st.failed = 1'b1;
                    st.segment_nonempty = 1'b0;
                end
                else if (c == upqv_pkg::CH_PERCENT)
                    st.hex_pending = upqv_pkg::HEX_DIGITS;
                else if (c == upqv_pkg::CH_QUESTION)
                begin
                    st.in_query            = 1'b1;
                    st.query_started_empty = 1'b1;
                end
                else if (upqv_pkg::in_segment_class(c))
                    st.segment_nonempty = 1'b1;
                else
                    st.failed = 1'b1;
            end
            else
            begin
                st.query_started_empty = 1'b0;
                if (c == upqv_pkg::CH_EQUAL)
                begin
                    if (!state_reg.part_nonempty || state_reg.in_value)
                        st.failed = 1'b1;
                    st.part_nonempty = 1'b0;
                    st.in_value      = 1'b1;
                end
                else if (c == upqv_pkg::CH_AMP)
                begin
                    if (!state_reg.part_nonempty || !state_reg.in_value)
                        st.failed = 1'b1;
                    st.part_nonempty = 1'b0;
                    st.in_value      = 1'b0;
                end
                else if (c == upqv_pkg::CH_PERCENT)
                    st.hex_pending = upqv_pkg::HEX_DIGITS;
                else if (upqv_pkg::in_segment_class(c))
                    st.part_nonempty = 1'b1;
                else
                    st.failed = 1'b1;
            end
        end

        ok = !st.failed && st.seen_first && (st.hex_pending == 2'd0)
          && !(st.in_query && (st.query_started_empty || !st.in_value));

        // A final byte closes the target, so the flags start over for the next one.
        if (s1_last_reg)
            state_next = '0;
        else
            state_next = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
                state_reg <= state_next;
            if (advance && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_char_reg <= character;
            s1_last_reg <= last_char;
        end
        if (advance && s1_last_reg)
            accepted_reg <= ok;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_last_reg |=> state_reg == '0)
        else $error("parse flags not cleared after a final byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hex_pending != 2'd3)
        else $error("escape digit count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && s1_last_reg))
        else $error("verdict produced without a final byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_last_reg && out_valid_reg)
        else $error("input stalled without a blocked verdict");

endmodule
